// ===== rtl/gcode_motion_line_parser_macros.svh =====
// Assertion macros shared by the G-code line parser RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GCODE_MOTION_LINE_PARSER_MACROS_SVH
`define GCODE_MOTION_LINE_PARSER_MACROS_SVH

// Same-cycle implication.
`define GMLP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GMLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gmlp_pkg.sv =====
// Shared types, character codes and helper functions for the G-code line parser.
// No dependencies.
`timescale 1ns / 1ps

package gmlp_pkg;

  localparam int OUT_W = 32;

  typedef enum logic [3:0] {
    LT_NONE = 4'd0,
    LT_G, LT_M, LT_X, LT_Y, LT_Z, LT_I, LT_J, LT_K, LT_R, LT_F, LT_N
  } letter_e;

  typedef enum logic [2:0] {
    MODE_RAPID = 3'd0,
    MODE_LINE,
    MODE_CW,
    MODE_CCW,
    MODE_NONE
  } mode_e;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // Control part of one queued beat from front to back.
  typedef struct packed {
    logic    eol;
    logic    word;
    logic    disc;
    logic    neg;
    letter_e letter;
  } item_ctl_t;

  // Smallest b with 2**b > 10**n.
  function automatic int pow10_bits(int n);
    longint unsigned p;
    int              b;
    p = 1;
    b = 0;
    for (int i = 0; i < n; i++) p = p * 10;
    while ((64'd1 << b) <= p) b++;
    return b;
  endfunction

  function automatic letter_e letter_of(logic [7:0] c);
    case (c)
      "G":     return LT_G;
      "M":     return LT_M;
      "X":     return LT_X;
      "Y":     return LT_Y;
      "Z":     return LT_Z;
      "I":     return LT_I;
      "J":     return LT_J;
      "K":     return LT_K;
      "R":     return LT_R;
      "F":     return LT_F;
      "N":     return LT_N;
      default: return LT_NONE;
    endcase
  endfunction

endpackage

// ===== rtl/gmlp_front.sv =====
// Front end: folds case, collects word letters and number prefixes, queues words and line ends.
// Depends on gmlp_pkg.
`timescale 1ns / 1ps

module gmlp_front #(
  parameter int NUMBER_CHARS = 9,
  parameter int MW           = 30,
  parameter int FW           = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_stream_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output gmlp_pkg::item_ctl_t push_ctl_o,
  output logic [MW-1:0]       push_mant_o,
  output logic [FW-1:0]       push_fd_o
);
  import gmlp_pkg::*;

  localparam int CW = $clog2(NUMBER_CHARS + 1);

  letter_e       letter_q, letter_d;
  logic [MW-1:0] mant_q, mant_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [FW-1:0] fd_q, fd_d;
  logic          neg_q, neg_d, dot_q, dot_d, stop_q, stop_d, disc_q, disc_d;

  logic [7:0] ch;
  logic       accept, is_eol, is_num, collecting;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign collecting = (letter_q != LT_NONE);

  always_comb begin
    ch = data_byte_i;
    if (ch inside {[CH_LC_A:CH_LC_Z]}) begin
      ch = data_byte_i - CASE_BIT;
    end
  end

  assign is_eol = end_of_stream_i || (ch == CH_NL);
  assign is_num = ch inside {[CH_ZERO:CH_NINE], CH_DOT, CH_MINUS};

  assign push_mant_o = mant_q;
  assign push_fd_o   = fd_q;

  always_comb begin
    letter_d   = letter_q;
    mant_d     = mant_q;
    cnt_d      = cnt_q;
    fd_d       = fd_q;
    neg_d      = neg_q;
    dot_d      = dot_q;
    stop_d     = stop_q;
    disc_d     = disc_q;
    push_o     = 1'b0;
    push_ctl_o = '{eol: 1'b0, word: collecting, disc: disc_q, neg: neg_q, letter: letter_q};
    if (accept) begin
      if (is_eol) begin
        push_o         = 1'b1;
        push_ctl_o.eol = 1'b1;
        disc_d         = 1'b0;
      end else if (!disc_q) begin
        if (collecting && is_num) begin
          if (cnt_q < CW'(NUMBER_CHARS)) begin
            cnt_d = cnt_q + CW'(1);
            if (!stop_q) begin
              if (ch == CH_MINUS) begin
                if (cnt_q == '0) neg_d = 1'b1;
                else stop_d = 1'b1;
              end else if (ch == CH_DOT) begin
                if (dot_q) stop_d = 1'b1;
                else dot_d = 1'b1;
              end else begin
                mant_d = MW'({mant_q, 3'b000}) + MW'({mant_q, 1'b0}) + MW'(ch[3:0]);
                if (dot_q) fd_d = fd_q + FW'(1);
              end
            end
          end
        end else begin
          push_o = collecting;
          if (ch == CH_LPAREN || ch == CH_O) disc_d = 1'b1;
        end
      end
      // Any beat that ended the word restarts the number collector.
      if (is_eol || (!disc_q && !(collecting && is_num))) begin
        letter_d = is_eol ? LT_NONE : letter_of(ch);
        mant_d   = '0;
        cnt_d    = '0;
        fd_d     = '0;
        neg_d    = 1'b0;
        dot_d    = 1'b0;
        stop_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= LT_NONE;
      mant_q   <= '0;
      cnt_q    <= '0;
      fd_q     <= '0;
      neg_q    <= 1'b0;
      dot_q    <= 1'b0;
      stop_q   <= 1'b0;
      disc_q   <= 1'b0;
    end else begin
      letter_q <= letter_d;
      mant_q   <= mant_d;
      cnt_q    <= cnt_d;
      fd_q     <= fd_d;
      neg_q    <= neg_d;
      dot_q    <= dot_d;
      stop_q   <= stop_d;
      disc_q   <= disc_d;
    end
  end

endmodule

// ===== rtl/gmlp_fifo.sv =====
// Four-entry queue between front and back ends.
// Depends on gcode_motion_line_parser_macros.svh.
`timescale 1ns / 1ps
`include "gcode_motion_line_parser_macros.svh"

module gmlp_fifo #(
  parameter int W = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  `GMLP_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `GMLP_ASSERT_NOW(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `GMLP_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count did not rise")

endmodule

// ===== rtl/gmlp_back.sv =====
// Back end: scales queued numbers to fixed point, updates modal state, emits moves.
// Depends on gmlp_pkg.
`timescale 1ns / 1ps

module gmlp_back #(
  parameter int NUMBER_CHARS = 9,
  parameter int FRAC_BITS    = 16,
  parameter int VALUE_WIDTH  = 32,
  parameter int MW           = 30,
  parameter int FW           = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        pop_o,
  input  logic                        empty_i,
  input  gmlp_pkg::item_ctl_t         ctl_i,
  input  logic [MW-1:0]               mant_i,
  input  logic [FW-1:0]               fd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  move_kind_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] target_x_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] target_y_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] arc_center_i_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] arc_center_j_o
);
  import gmlp_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = VALUE_WIDTH;
  localparam int DW  = pow10_bits(NUMBER_CHARS - 1);
  localparam int XW  = MW + F;
  localparam int QW  = XW;
  localparam int RW  = XW + 1;
  localparam int LO  = (MW < RW / 2) ? MW : RW / 2;
  localparam int HI  = RW - LO;
  localparam int SW  = MW + HI + 1;
  localparam int RMW = DW + 1;
  localparam int CW  = ((QW > VW) ? QW : VW) + 1;
  localparam int KW  = VW + F + 2;
  localparam logic [CW-1:0] LIM = CW'(1) << (VW - 1);

  // Reciprocal and power-of-ten tables, one row per fraction digit count.
  logic [RW-1:0] recip_tab [2**FW];
  logic [DW-1:0] p10_tab   [2**FW];

  for (genvar g = 0; g < 2**FW; g++) begin : g_tab
    localparam int            E   = (g < NUMBER_CHARS) ? g : NUMBER_CHARS - 1;
    localparam logic [DW-1:0] P10 = DW'(10) ** E;
    localparam logic [RW-1:0] RCP = {1'b1, {XW{1'b0}}} / RW'(P10);
    assign recip_tab[g] = RCP;
    assign p10_tab[g]   = P10;
  end

  logic back_en;
  logic out_valid_q, out_valid_d;

  assign back_en = !out_valid_q || out_ready_i;
  assign pop_o   = back_en && !empty_i;

  // Stage 1: low partial product.
  logic             v1_q;
  item_ctl_t        c1_q;
  logic [MW-1:0]    m1_q;
  logic [FW-1:0]    f1_q;
  logic [MW+LO-1:0] plo1_q;
  logic [RW-1:0]    rcp0, rcp1;

  assign rcp0 = recip_tab[fd_i];
  assign rcp1 = recip_tab[f1_q];

  // Stage 2: high partial product and quotient estimate.
  logic          v2_q;
  item_ctl_t     c2_q;
  logic [MW-1:0] m2_q;
  logic [FW-1:0] f2_q;
  logic [QW-1:0] q0_2_q;
  logic [SW-1:0] sum2;

  assign sum2 = SW'(m1_q) * SW'(rcp1[RW-1:LO]) + SW'(plo1_q >> LO);

  // Stage 3: back-multiply the estimate.
  logic           v3_q;
  item_ctl_t      c3_q;
  logic [MW-1:0]  m3_q;
  logic [FW-1:0]  f3_q;
  logic [QW-1:0]  q0_3_q;
  logic [RMW-1:0] prod3_q;

  // Stage 4: correction, exactness, saturation.
  logic           v4_q;
  item_ctl_t      c4_q;
  logic [VW-1:0]  val4_q, val4_d;
  logic           exact4_q, exact4_d;
  logic [RMW-1:0] xlow, rem, rem_fin, dv;
  logic           ge;
  logic [QW-1:0]  qf;
  logic [CW-1:0]  qx;
  logic [MW-1:0]  lowmask;

  always_comb begin
    xlow     = RMW'({m3_q, {F{1'b0}}});
    dv       = RMW'(p10_tab[f3_q]);
    rem      = xlow - prod3_q;
    ge       = (rem >= dv);
    rem_fin  = ge ? rem - dv : rem;
    qf       = q0_3_q + QW'(ge);
    qx       = CW'(qf);
    lowmask  = ~({MW{1'b1}} << f3_q);
    exact4_d = (rem_fin == '0) && ((m3_q & lowmask) == '0);
    if (c3_q.neg) begin
      val4_d = (qx > LIM) ? VW'(0) - VW'(LIM) : VW'(0) - VW'(qx);
    end else begin
      val4_d = (qx > LIM - CW'(1)) ? VW'(LIM - CW'(1)) : VW'(qx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      c1_q     <= ctl_i;
      m1_q     <= mant_i;
      f1_q     <= fd_i;
      plo1_q   <= (MW+LO)'(mant_i) * (MW+LO)'(rcp0[LO-1:0]);
      c2_q     <= c1_q;
      m2_q     <= m1_q;
      f2_q     <= f1_q;
      q0_2_q   <= QW'(sum2 >> (MW - LO));
      c3_q     <= c2_q;
      m3_q     <= m2_q;
      f3_q     <= f2_q;
      q0_3_q   <= q0_2_q;
      prod3_q  <= RMW'(q0_2_q[RMW-1:0] * RMW'(p10_tab[f2_q]));
      c4_q     <= c3_q;
      val4_q   <= val4_d;
      exact4_q <= exact4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (back_en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 5: commit to modal state.
  logic [VW-1:0] x_q, x_d, y_q, y_d, i_q, i_d, j_q, j_d, last_q, last_d;
  logic          any_q, any_d, k_q, k_d, g_q, g_d, ex_q, ex_d;
  logic [2:0]    mode_q, mode_d;
  logic          emit;
  logic [1:0]    kind_q;
  logic [VW-1:0] ox_q, oy_q, oi_q, oj_q;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    i_d    = i_q;
    j_d    = j_q;
    last_d = last_q;
    any_d  = any_q;
    k_d    = k_q;
    g_d    = g_q;
    ex_d   = ex_q;
    mode_d = mode_q;
    emit   = 1'b0;
    if (v4_q && back_en) begin
      if (c4_q.word) begin
        case (c4_q.letter)
          LT_G: begin
            g_d    = 1'b1;
            last_d = val4_q;
            ex_d   = exact4_q;
          end
          LT_X: begin
            x_d   = val4_q;
            any_d = 1'b1;
          end
          LT_Y: begin
            y_d   = val4_q;
            any_d = 1'b1;
          end
          LT_I: begin
            i_d   = val4_q;
            any_d = 1'b1;
          end
          LT_J: begin
            j_d   = val4_q;
            any_d = 1'b1;
          end
          LT_K: begin
            any_d = 1'b1;
            k_d   = 1'b1;
          end
          LT_Z, LT_R, LT_F: begin
            any_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (c4_q.eol) begin
        if (any_d && !c4_q.disc) begin
          if (g_d) begin
            mode_d = MODE_NONE;
            for (int k = 0; k < 4; k++) begin
              if (ex_d && ({{(F+2){1'b0}}, last_d} == (KW'(k) << F))) mode_d = 3'(k);
            end
          end
          emit = (mode_d == MODE_RAPID) || (mode_d == MODE_LINE) ||
                 (((mode_d == MODE_CW) || (mode_d == MODE_CCW)) && !k_d);
        end
        any_d  = 1'b0;
        k_d    = 1'b0;
        g_d    = 1'b0;
        ex_d   = 1'b0;
        last_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (back_en) out_valid_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      last_q      <= '0;
      any_q       <= 1'b0;
      k_q         <= 1'b0;
      g_q         <= 1'b0;
      ex_q        <= 1'b0;
      mode_q      <= MODE_NONE;
      out_valid_q <= 1'b0;
    end else begin
      x_q         <= x_d;
      y_q         <= y_d;
      i_q         <= i_d;
      j_q         <= j_d;
      last_q      <= last_d;
      any_q       <= any_d;
      k_q         <= k_d;
      g_q         <= g_d;
      ex_q        <= ex_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en && emit) begin
      kind_q <= mode_d[1:0];
      ox_q   <= x_d;
      oy_q   <= y_d;
      oi_q   <= mode_d[1] ? i_d : '0;
      oj_q   <= mode_d[1] ? j_d : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign move_kind_o    = kind_q;
  assign target_x_o     = OUT_W'($signed(ox_q));
  assign target_y_o     = OUT_W'($signed(oy_q));
  assign arc_center_i_o = OUT_W'($signed(oi_q));
  assign arc_center_j_o = OUT_W'($signed(oj_q));

endmodule

// ===== rtl/gcode_motion_line_parser.sv =====
// Top level of the G-code motion line parser: front end, queue, back end.
// Depends on gmlp_pkg, gmlp_front, gmlp_fifo, gmlp_back.
`timescale 1ns / 1ps

//  channel | direction | handshake                  | beat payload
//  in      | sink      | in_valid_i / in_ready_o    | data_byte_i, end_of_stream_i
//  out     | source    | out_valid_o / out_ready_i  | move_kind_o, target_*, arc_center_*
//
// One byte per cycle while in_ready_o is high; the front end takes each byte as it is accepted.
// A move becomes valid after the newline beat passes the queue, four back-end
// stages (two partial products, back-multiply, correction) and the commit, which
// loads the modal state and the output register on the same edge.
// Reset is asynchronous and active low; all modal state clears at once, no sweep.
// A stalled output freezes the back end; the four-deep queue absorbs the front
// until it fills, then in_ready_o drops.

module gcode_motion_line_parser #(
  parameter int FRAC_BITS    = 16,
  parameter int NUMBER_CHARS = 9,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              end_of_stream_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        move_kind_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] target_x_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] target_y_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] arc_center_i_o,
  output logic signed [gmlp_pkg::OUT_W-1:0] arc_center_j_o
);
  import gmlp_pkg::*;

  // Mantissa holds up to NUMBER_CHARS decimal digits; fd counts fraction digits.
  localparam int MW     = pow10_bits(NUMBER_CHARS);
  localparam int FW     = $clog2(NUMBER_CHARS);
  localparam int ITEM_W = $bits(item_ctl_t) + MW + FW;

  logic          push, full, pop, empty;
  item_ctl_t     push_ctl, pop_ctl;
  logic [MW-1:0] push_mant, pop_mant;
  logic [FW-1:0] push_fd, pop_fd;
  logic [ITEM_W-1:0] rdata;

  gmlp_front #(
    .NUMBER_CHARS(NUMBER_CHARS),
    .MW          (MW),
    .FW          (FW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .push_o         (push),
    .push_ready_i   (!full),
    .push_ctl_o     (push_ctl),
    .push_mant_o    (push_mant),
    .push_fd_o      (push_fd)
  );

  gmlp_fifo #(
    .W(ITEM_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_ctl, push_mant, push_fd}),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(rdata),
    .empty_o(empty)
  );

  assign {pop_ctl, pop_mant, pop_fd} = rdata;

  gmlp_back #(
    .NUMBER_CHARS(NUMBER_CHARS),
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .MW          (MW),
    .FW          (FW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_o         (pop),
    .empty_i       (empty),
    .ctl_i         (pop_ctl),
    .mant_i        (pop_mant),
    .fd_i          (pop_fd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .move_kind_o   (move_kind_o),
    .target_x_o    (target_x_o),
    .target_y_o    (target_y_o),
    .arc_center_i_o(arc_center_i_o),
    .arc_center_j_o(arc_center_j_o)
  );

endmodule
